@@ hw/rtl/suwt_pkg.sv @@
// Shared constants, operation codes, payload types and a helper for the word table.
package suwt_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int OP_W   = 4;

    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd0;
    localparam logic [OP_W-1:0] OP_APPEND     = 4'd1;
    localparam logic [OP_W-1:0] OP_APPEND_U   = 4'd2;
    localparam logic [OP_W-1:0] OP_SORTED     = 4'd3;
    localparam logic [OP_W-1:0] OP_SORTED_U   = 4'd4;
    localparam logic [OP_W-1:0] OP_GET        = 4'd5;
    localparam logic [OP_W-1:0] OP_FIRST      = 4'd6;
    localparam logic [OP_W-1:0] OP_NEXT       = 4'd7;
    localparam logic [OP_W-1:0] OP_FIND_FIRST = 4'd8;
    localparam logic [OP_W-1:0] OP_FIND_NEXT  = 4'd9;
    localparam logic [OP_W-1:0] OP_DELETE     = 4'd10;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_PUT  = 2'd1;
    localparam logic [1:0] CELL_INS  = 2'd2;
    localparam logic [1:0] CELL_DEL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  position;
    } t_cmd;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] value_out;
        logic [POS_W-1:0]  index_out;
        logic              is_empty;
    } t_result;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] target;
    } t_cell_cmd;

    // Returns a found flag above the index of the lowest set bit.
    function automatic logic [IDX_W:0] first_set(input logic [DEPTH-1:0] v);
        logic [IDX_W:0] r;
        r = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, IDX_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/suwt_cell.sv @@
// One table cell: holds a word, compares it with the operand and shifts with its neighbors.
module suwt_cell (
    input  logic                      i_clk,
    input  suwt_pkg::t_cell_cmd       i_cmd,
    input  logic [suwt_pkg::IDX_W-1:0]  i_index,
    input  logic [suwt_pkg::WORD_W-1:0] i_new_word,
    input  logic [suwt_pkg::WORD_W-1:0] i_left_word,
    input  logic [suwt_pkg::WORD_W-1:0] i_right_word,
    output logic [suwt_pkg::WORD_W-1:0] o_word,
    output logic                      o_eq,
    output logic                      o_ge
);

    logic [suwt_pkg::WORD_W-1:0] r_word;
    logic [suwt_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_cmd.mode)
            suwt_pkg::CELL_HOLD: begin
                n_word = r_word;
            end
            suwt_pkg::CELL_PUT: begin
                if (i_index == i_cmd.target) begin
                    n_word = i_new_word;
                end
            end
            suwt_pkg::CELL_INS: begin
                if (i_index == i_cmd.target) begin
                    n_word = i_new_word;
                end else if (i_index > i_cmd.target) begin
                    n_word = i_left_word;
                end
            end
            suwt_pkg::CELL_DEL: begin
                if (i_index >= i_cmd.target) begin
                    n_word = i_right_word;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_eq   = (r_word == i_new_word);
    assign o_ge   = (r_word >= i_new_word);

endmodule

@@ hw/rtl/sorted_unique_word_table.sv @@
// Top level of the word table: command capture, compare stage, cell chain and result register.
//
//   Channel   Direction  Transfer condition      Payload
//   command   in         start && !busy          i_cmd (operation, value, position)
//   result    out        o_valid (one cycle)     o_result (ok, value_out, index_out, is_empty)
//
// Every command passes through capture, compare across all cells, then execute.
// The execute cycle shifts or writes the whole cell chain at once.
// The result appears for one cycle after execute, when busy is already low again.
// Reset is synchronous and clears the fill count, the cursor and the control state.
// The receiver cannot stall, so the block never waits on the result side.
module sorted_unique_word_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  suwt_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_valid,
    output suwt_pkg::t_result o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]                    r_state,  n_state;
    suwt_pkg::t_cmd                r_cmd;
    logic [suwt_pkg::POS_W-1:0]    r_count,  n_count;
    logic [suwt_pkg::POS_W-1:0]    r_cursor, n_cursor;
    logic [suwt_pkg::DEPTH-1:0]    r_eqv, r_ge, r_hit;
    logic                          r_valid,  n_valid;
    suwt_pkg::t_result             r_result, n_result;

    logic [suwt_pkg::WORD_W-1:0]   w_word [suwt_pkg::DEPTH];
    logic [suwt_pkg::DEPTH-1:0]    w_eq, w_ge, w_live, w_after;
    logic [suwt_pkg::POS_W-1:0]    w_start;
    suwt_pkg::t_cell_cmd           w_cell_cmd;

    logic [suwt_pkg::IDX_W:0]      w_ge_first, w_hit_first;
    logic                          w_full, w_pos_ok, w_dup_sorted;
    logic [suwt_pkg::POS_W-1:0]    w_pos_m1;
    logic [suwt_pkg::IDX_W-1:0]    w_rd_idx, w_ins_idx;
    logic [suwt_pkg::WORD_W-1:0]   w_rd_word;

    assign w_start = (r_cmd.operation == suwt_pkg::OP_FIND_NEXT) ? r_cursor : '0;

    genvar g;
    generate
        for (g = 0; g < suwt_pkg::DEPTH; g++) begin : g_cell
            logic [suwt_pkg::WORD_W-1:0] w_left, w_right;
            if (g == 0) begin : g_first
                assign w_left = r_cmd.value;
            end else begin : g_mid_l
                assign w_left = w_word[g-1];
            end
            if (g == suwt_pkg::DEPTH - 1) begin : g_last
                assign w_right = w_word[g];
            end else begin : g_mid_r
                assign w_right = w_word[g+1];
            end

            suwt_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cell_cmd),
                .i_index      (suwt_pkg::IDX_W'(g)),
                .i_new_word   (r_cmd.value),
                .i_left_word  (w_left),
                .i_right_word (w_right),
                .o_word       (w_word[g]),
                .o_eq         (w_eq[g]),
                .o_ge         (w_ge[g])
            );

            assign w_live[g]  = (suwt_pkg::POS_W'(g) < r_count);
            assign w_after[g] = (suwt_pkg::POS_W'(g) >= w_start);
        end
    endgenerate

    assign w_ge_first   = suwt_pkg::first_set(r_ge);
    assign w_hit_first  = suwt_pkg::first_set(r_hit);
    assign w_full       = (r_count == suwt_pkg::POS_W'(suwt_pkg::DEPTH));
    assign w_pos_ok     = (r_cmd.position != '0) && (r_cmd.position <= r_count);
    assign w_pos_m1     = r_cmd.position - suwt_pkg::POS_W'(1);
    assign w_ins_idx    = w_ge_first[suwt_pkg::IDX_W] ? w_ge_first[suwt_pkg::IDX_W-1:0]
                                                      : r_count[suwt_pkg::IDX_W-1:0];
    assign w_dup_sorted = w_ge_first[suwt_pkg::IDX_W] &&
                          r_eqv[w_ge_first[suwt_pkg::IDX_W-1:0]];

    always_comb begin
        priority if (r_cmd.operation == suwt_pkg::OP_GET) begin
            w_rd_idx = w_pos_m1[suwt_pkg::IDX_W-1:0];
        end else if (r_cmd.operation == suwt_pkg::OP_NEXT) begin
            w_rd_idx = r_cursor[suwt_pkg::IDX_W-1:0];
        end else begin
            w_rd_idx = '0;
        end
    end

    assign w_rd_word = w_word[w_rd_idx];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_valid    = 1'b0;
        n_result   = '0;
        w_cell_cmd = '{mode: suwt_pkg::CELL_HOLD, target: '0};
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                case (r_cmd.operation)
                    suwt_pkg::OP_CLEAR: begin
                        n_count     = '0;
                        n_cursor    = '0;
                        n_result.ok = 1'b1;
                    end
                    suwt_pkg::OP_APPEND, suwt_pkg::OP_APPEND_U: begin
                        if (!w_full && !((r_cmd.operation == suwt_pkg::OP_APPEND_U) &&
                                         (|r_eqv))) begin
                            w_cell_cmd  = '{mode: suwt_pkg::CELL_PUT,
                                            target: r_count[suwt_pkg::IDX_W-1:0]};
                            n_count     = r_count + suwt_pkg::POS_W'(1);
                            n_result.ok = 1'b1;
                        end
                    end
                    suwt_pkg::OP_SORTED, suwt_pkg::OP_SORTED_U: begin
                        if (!w_full && !((r_cmd.operation == suwt_pkg::OP_SORTED_U) &&
                                         w_dup_sorted)) begin
                            w_cell_cmd  = '{mode: suwt_pkg::CELL_INS, target: w_ins_idx};
                            n_count     = r_count + suwt_pkg::POS_W'(1);
                            n_result.ok = 1'b1;
                        end
                    end
                    suwt_pkg::OP_GET: begin
                        if (w_pos_ok) begin
                            n_result.ok        = 1'b1;
                            n_result.value_out = w_rd_word;
                        end
                    end
                    suwt_pkg::OP_FIRST: begin
                        if (r_count != '0) begin
                            n_result.ok        = 1'b1;
                            n_result.value_out = w_rd_word;
                            n_cursor           = suwt_pkg::POS_W'(1);
                        end else begin
                            n_cursor = '0;
                        end
                    end
                    suwt_pkg::OP_NEXT: begin
                        if ((r_cursor != '0) && (r_cursor < r_count)) begin
                            n_result.ok        = 1'b1;
                            n_result.value_out = w_rd_word;
                            n_cursor           = r_cursor + suwt_pkg::POS_W'(1);
                        end else begin
                            n_cursor = '0;
                        end
                    end
                    suwt_pkg::OP_FIND_FIRST, suwt_pkg::OP_FIND_NEXT: begin
                        if (w_hit_first[suwt_pkg::IDX_W]) begin
                            n_result.ok        = 1'b1;
                            n_result.index_out =
                                suwt_pkg::POS_W'(w_hit_first[suwt_pkg::IDX_W-1:0]) +
                                suwt_pkg::POS_W'(1);
                            n_cursor           = n_result.index_out;
                        end else begin
                            n_cursor = '0;
                        end
                    end
                    suwt_pkg::OP_DELETE: begin
                        if (w_pos_ok) begin
                            w_cell_cmd  = '{mode: suwt_pkg::CELL_DEL,
                                            target: w_pos_m1[suwt_pkg::IDX_W-1:0]};
                            n_count     = r_count - suwt_pkg::POS_W'(1);
                            n_result.ok = 1'b1;
                        end
                    end
                    default: begin
                        n_result.ok = 1'b0;
                    end
                endcase
                n_result.is_empty = (n_count == '0);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_CMP) begin
            r_eqv <= w_eq & w_live;
            r_ge  <= w_ge & w_live;
            r_hit <= w_eq & w_live & w_after;
        end
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hw/rtl/suwt_checker.sv @@
// Port-level checker for the word table and the bind that attaches it.
module suwt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_busy,
    input logic              i_valid,
    input suwt_pkg::t_result i_result
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) ##1 i_rst_n ##1 i_rst_n |=> i_valid)
        else $error("A transfer on the command side gave no result three cycles later.");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("The block is busy while a result is shown.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid)
        else $error("The result strobe stayed high for two cycles.");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_result.ok) |->
        ((i_result.value_out == '0) && (i_result.index_out == '0)))
        else $error("A failed operation returned a nonzero word or index.");

endmodule

bind sorted_unique_word_table suwt_checker u_suwt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_valid  (o_valid),
    .i_result (o_result)
);

@@ tb/tb_sorted_unique_word_table.sv @@
// Self-checking testbench for the sorted unique word table.
`timescale 1ns / 1ps

module tb_sorted_unique_word_table;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    suwt_pkg::t_cmd    i_cmd;
    logic              busy;
    logic              o_valid;
    suwt_pkg::t_result o_result;

    sorted_unique_word_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    suwt_pkg::t_cmd    pending_cmds[$];
    suwt_pkg::t_result expected_results[$];

    logic [suwt_pkg::WORD_W-1:0] tbl_words [suwt_pkg::DEPTH];
    int tbl_count  = 0;
    int tbl_cursor = 0;
    int gen_fill   = 0;

    int n_errors     = 0;
    int n_commands   = 0;
    int n_results    = 0;
    int n_succeeded  = 0;
    int n_full_hits  = 0;
    int n_popped     = 0;
    int burst_left   = 4;
    int gap_left     = 0;

    function automatic suwt_pkg::t_result table_op(input suwt_pkg::t_cmd c);
        suwt_pkg::t_result r;
        int      i;
        int      at;
        int      first_idx;
        int      p;
        logic    hit;
        r = '0;
        p = c.position;
        case (c.operation)
            suwt_pkg::OP_CLEAR: begin
                tbl_count  = 0;
                tbl_cursor = 0;
                r.ok       = 1'b1;
            end
            suwt_pkg::OP_APPEND, suwt_pkg::OP_APPEND_U: begin
                if (tbl_count >= suwt_pkg::DEPTH) begin
                    n_full_hits++;
                end else begin
                    hit = 1'b0;
                    if (c.operation == suwt_pkg::OP_APPEND_U) begin
                        for (i = 0; i < tbl_count; i++) begin
                            if (tbl_words[i] == c.value) begin
                                hit = 1'b1;
                            end
                        end
                    end
                    if (!hit) begin
                        tbl_words[tbl_count] = c.value;
                        tbl_count++;
                        r.ok = 1'b1;
                    end
                end
            end
            suwt_pkg::OP_SORTED, suwt_pkg::OP_SORTED_U: begin
                if (tbl_count >= suwt_pkg::DEPTH) begin
                    n_full_hits++;
                end else begin
                    at = tbl_count;
                    for (i = tbl_count - 1; i >= 0; i--) begin
                        if (tbl_words[i] >= c.value) begin
                            at = i;
                        end
                    end
                    if (!(c.operation == suwt_pkg::OP_SORTED_U && at < tbl_count
                          && tbl_words[at] == c.value)) begin
                        for (i = tbl_count; i > at; i--) begin
                            tbl_words[i] = tbl_words[i-1];
                        end
                        tbl_words[at] = c.value;
                        tbl_count++;
                        r.ok = 1'b1;
                    end
                end
            end
            suwt_pkg::OP_GET: begin
                if (p > 0 && p <= tbl_count) begin
                    r.value_out = tbl_words[p-1];
                    r.ok        = 1'b1;
                end
            end
            suwt_pkg::OP_FIRST: begin
                if (tbl_count > 0) begin
                    r.value_out = tbl_words[0];
                    tbl_cursor  = 1;
                    r.ok        = 1'b1;
                end else begin
                    tbl_cursor = 0;
                end
            end
            suwt_pkg::OP_NEXT: begin
                if (tbl_cursor > 0 && tbl_cursor < tbl_count) begin
                    r.value_out = tbl_words[tbl_cursor];
                    tbl_cursor++;
                    r.ok = 1'b1;
                end else begin
                    tbl_cursor = 0;
                end
            end
            suwt_pkg::OP_FIND_FIRST, suwt_pkg::OP_FIND_NEXT: begin
                first_idx = (c.operation == suwt_pkg::OP_FIND_FIRST) ? 0 : tbl_cursor;
                hit = 1'b0;
                at  = 0;
                for (i = first_idx; i < tbl_count; i++) begin
                    if (!hit && tbl_words[i] == c.value) begin
                        hit = 1'b1;
                        at  = i;
                    end
                end
                if (hit) begin
                    tbl_cursor  = at + 1;
                    r.index_out = suwt_pkg::POS_W'(at + 1);
                    r.ok        = 1'b1;
                end else begin
                    tbl_cursor = 0;
                end
            end
            suwt_pkg::OP_DELETE: begin
                if (p > 0 && p <= tbl_count) begin
                    for (i = p - 1; i < tbl_count - 1; i++) begin
                        tbl_words[i] = tbl_words[i+1];
                    end
                    tbl_count--;
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.is_empty = (tbl_count == 0);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        suwt_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, o_result);
                end else begin
                    want = expected_results.pop_front();
                    if (want.ok) begin
                        n_succeeded++;
                    end
                    check_field("ok", 32'(want.ok), 32'(o_result.ok));
                    check_field("value_out", want.value_out, o_result.value_out);
                    check_field("index_out", 32'(want.index_out), 32'(o_result.index_out));
                    check_field("is_empty", 32'(want.is_empty), 32'(o_result.is_empty));
                end
            end
            if (start && !busy) begin
                expected_results.push_back(table_op(i_cmd));
                n_commands++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (n_popped < n_commands) begin
                n_popped++;
                void'(pending_cmds.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                start <= 1'b1;
                i_cmd <= pending_cmds[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_cmd(input logic [suwt_pkg::OP_W-1:0] op,
                            input logic [suwt_pkg::WORD_W-1:0] word,
                            input logic [suwt_pkg::POS_W-1:0] pos);
        suwt_pkg::t_cmd c;
        c.operation = op;
        c.value     = word;
        c.position  = pos;
        pending_cmds.push_back(c);
        if (op == suwt_pkg::OP_CLEAR) begin
            gen_fill = 0;
        end else if (op >= suwt_pkg::OP_APPEND && op <= suwt_pkg::OP_SORTED_U &&
                     gen_fill < suwt_pkg::DEPTH) begin
            gen_fill++;
        end else if (op == suwt_pkg::OP_DELETE && pos > 0 && pos <= gen_fill) begin
            gen_fill--;
        end
    endtask

    function automatic logic [suwt_pkg::WORD_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 10) begin
            case ($urandom_range(0, 7))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'h0000_0005;
                3: return 32'h0000_1234;
                4: return 32'h55AA_55AA;
                5: return 32'h7FFF_FFFF;
                6: return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end else if (roll < 12) begin
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return $urandom;
    endfunction

    function automatic logic [suwt_pkg::POS_W-1:0] pick_pos();
        if ($urandom_range(0, 3) != 0) begin
            return suwt_pkg::POS_W'($urandom_range(1, (gen_fill > 0) ? gen_fill : 1));
        end
        return suwt_pkg::POS_W'($urandom_range(0, 127));
    endfunction

    task automatic build_and_walk(input bit sorted_only);
        int n;
        int k;
        logic [suwt_pkg::OP_W-1:0] op;
        push_cmd(suwt_pkg::OP_CLEAR, pick_word(), pick_pos());
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
        for (k = 0; k < n; k++) begin
            if (sorted_only) begin
                op = $urandom_range(0, 1) ? suwt_pkg::OP_SORTED_U : suwt_pkg::OP_SORTED;
            end else begin
                op = suwt_pkg::OP_W'($urandom_range(1, 4));
            end
            push_cmd(op, pick_word(), pick_pos());
        end
        push_cmd(suwt_pkg::OP_FIRST, pick_word(), pick_pos());
        for (k = 0; k < n + 1; k++) begin
            push_cmd(suwt_pkg::OP_NEXT, pick_word(), pick_pos());
        end
    endtask

    initial begin
        int k;
        int j;
        int reps;
        logic [suwt_pkg::WORD_W-1:0] w;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;

        push_cmd(suwt_pkg::OP_GET,         32'h0,          7'd1);
        push_cmd(suwt_pkg::OP_DELETE,      32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_FIRST,       32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_NEXT,        32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_FIND_FIRST,  32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_FIND_NEXT,   32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_APPEND,      32'h0000_0000,  7'd0);
        push_cmd(suwt_pkg::OP_APPEND,      32'hFFFF_FFFF,  7'd127);
        push_cmd(suwt_pkg::OP_APPEND_U,    32'hFFFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_SORTED,      32'h7FFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_SORTED_U,    32'h7FFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_SORTED,      32'h7FFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_GET,         32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_GET,         32'h0,          7'd127);
        push_cmd(suwt_pkg::OP_GET,         32'h0,          7'd3);
        push_cmd(suwt_pkg::OP_FIRST,       32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_NEXT,        32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_FIND_FIRST,  32'h7FFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_FIND_NEXT,   32'h7FFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_FIND_NEXT,   32'h7FFF_FFFF,  7'd0);
        push_cmd(suwt_pkg::OP_DELETE,      32'h0,          7'd2);
        push_cmd(suwt_pkg::OP_DELETE,      32'h0,          7'd127);
        push_cmd(suwt_pkg::OP_W'(11),      32'hFFFF_FFFF,  7'd127);
        push_cmd(suwt_pkg::OP_W'(15),      32'h0,          7'd0);
        push_cmd(suwt_pkg::OP_CLEAR,       32'h0,          7'd0);

        while (pending_cmds.size() < 1275) begin
            case ($urandom_range(0, 9))
                0, 1: build_and_walk(1'b0);
                2, 3: build_and_walk(1'b1);
                4: begin
                    reps = $urandom_range(64, 70) - gen_fill;
                    for (k = 0; k < reps; k++) begin
                        push_cmd(suwt_pkg::OP_W'($urandom_range(1, 4)), pick_word(),
                                 pick_pos());
                    end
                end
                5, 6: begin
                    for (k = 0; k < 4; k++) begin
                        w = pick_word();
                        push_cmd(suwt_pkg::OP_FIND_FIRST, w, pick_pos());
                        reps = $urandom_range(1, 4);
                        for (j = 0; j < reps; j++) begin
                            push_cmd(suwt_pkg::OP_FIND_NEXT, w, pick_pos());
                        end
                    end
                end
                7, 8: begin
                    reps = $urandom_range(3, 10);
                    for (k = 0; k < reps; k++) begin
                        push_cmd($urandom_range(0, 1) ? suwt_pkg::OP_GET : suwt_pkg::OP_DELETE,
                                 pick_word(), pick_pos());
                    end
                end
                default: begin
                    reps = $urandom_range(5, 15);
                    for (k = 0; k < reps; k++) begin
                        push_cmd(suwt_pkg::OP_W'($urandom_range(0, 15)), $urandom,
                                 suwt_pkg::POS_W'($urandom_range(0, 127)));
                    end
                end
            endcase
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results, %0d of them successful.",
                 n_commands, n_results, n_succeeded);
        $display("Additions refused by a full table: %0d.", n_full_hits);
        if (n_errors == 0) begin
            $display("tb_sorted_unique_word_table: PASS");
        end else begin
            $display("tb_sorted_unique_word_table: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d commands pending and %0d results outstanding.",
                 pending_cmds.size(), expected_results.size());
        $display("tb_sorted_unique_word_table: FAIL");
        $finish;
    end

endmodule

@@ sorted_unique_word_table.f @@
hw/rtl/suwt_pkg.sv
hw/rtl/suwt_cell.sv
hw/rtl/sorted_unique_word_table.sv
hw/rtl/suwt_checker.sv
tb/tb_sorted_unique_word_table.sv
